// ===== sv/lfc_pkg.sv =====
// Package with the shared types, constants and the CRC byte step of the frame checker.
`timescale 1ns / 1ps

package lfc_pkg;

    localparam logic [31:0] LOG_MAGIC       = 32'h5644_4231;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES        = 32'hFFFF_FFFF;
    localparam int          LEN_W           = 27;
    localparam int          FRAME_OFFSET_W  = 40;
    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 27'd67108864;
    localparam int          HEADER_BYTES    = 12;
    localparam int          OFFSET_WIDTH_DEF = 40;
    localparam int          CMDQ_DEPTH_DEF  = 4;

    typedef enum logic [1:0] {
        ST_FRAME_OK          = 2'd0,
        ST_BAD_HEADER        = 2'd1,
        ST_CHECKSUM_MISMATCH = 2'd2,
        ST_TORN_TAIL         = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        K_SKIP        = 3'd0,
        K_EMIT        = 3'd1,
        K_CHECK_EMPTY = 3'd2,
        K_PAY         = 3'd3,
        K_PAY_END     = 3'd4
    } kind_t;

    // One classified byte passed from the parser to the checksum side.
    typedef struct packed {
        kind_t             kind;
        logic [7:0]        data_byte;
        logic              log_last;
        status_t           status;
        logic [LEN_W-1:0]  length;
        logic [31:0]       checksum;
    } cmd_t;

    typedef struct packed {
        status_t                    status;
        logic [LEN_W-1:0]           frame_length;
        logic [FRAME_OFFSET_W-1:0]  frame_offset;
        logic [31:0]                stored_checksum;
        logic                       log_done;
    } res_t;

    localparam int CMD_W = $bits(cmd_t);

    // Reflected CRC-32 update by one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] set_byte(input logic [31:0] word, input logic [1:0] lane,
                                             input logic [7:0] b);
        logic [4:0] sh;
        sh = {lane, 3'b000};
        return (word & ~(32'h0000_00FF << sh)) | ({24'd0, b} << sh);
    endfunction

endpackage

// ===== sv/lfc_front.sv =====
// Front end: assembles frame headers, tracks the log position and classifies each word.
`timescale 1ns / 1ps

module lfc_front #(
    parameter int OFFSET_WIDTH = lfc_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_log,
    input  logic [lfc_pkg::LEN_W-1:0]   max_frame_bytes,
    output lfc_pkg::cmd_t               cmd,
    output logic [OFFSET_WIDTH-1:0]     cmd_offset
);
    import lfc_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [LEN_W-1:0]        count_reg, count_next;
    logic [31:0]             magic_reg, magic_next;
    logic [31:0]             length_reg, length_next;
    logic [31:0]             crc_word_reg, crc_word_next;
    logic [OFFSET_WIDTH-1:0] pos_reg, pos_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;

    logic [31:0]             magic_w, length_w, crc_w;
    logic [LEN_W:0]          count_inc;
    logic                    first_byte;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg    <= PH_HEADER;
            count_reg    <= '0;
            magic_reg    <= '0;
            length_reg   <= '0;
            crc_word_reg <= '0;
            pos_reg      <= '0;
            start_reg    <= '0;
        end
        else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            magic_reg    <= magic_next;
            length_reg   <= length_next;
            crc_word_reg <= crc_word_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        magic_next    = magic_reg;
        length_next   = length_reg;
        crc_word_next = crc_word_reg;
        pos_next      = pos_reg;
        start_next    = start_reg;

        first_byte = (phase_reg == PH_HEADER) && (count_reg == '0);
        magic_w    = first_byte ? 32'd0 : magic_reg;
        length_w   = first_byte ? 32'd0 : length_reg;
        crc_w      = first_byte ? 32'd0 : crc_word_reg;
        count_inc  = {1'b0, count_reg} + 1'b1;

        cmd            = '0;
        cmd.kind       = K_SKIP;
        cmd.status     = ST_FRAME_OK;
        cmd.data_byte  = data_byte;
        cmd.log_last   = end_of_log;
        cmd_offset     = first_byte ? pos_reg : start_reg;

        case (count_reg[3:2])
            2'd0:    magic_w  = set_byte(magic_w, count_reg[1:0], data_byte);
            2'd1:    length_w = set_byte(length_w, count_reg[1:0], data_byte);
            default: crc_w    = set_byte(crc_w, count_reg[1:0], data_byte);
        endcase

        if (accept) begin
            pos_next = pos_reg + 1'b1;
            case (phase_reg)
                PH_HEADER:
                begin
                    magic_next    = magic_w;
                    length_next   = length_w;
                    crc_word_next = crc_w;
                    if (first_byte) begin
                        start_next = pos_reg;
                    end
                    if (count_reg == LEN_W'(HEADER_BYTES - 1)) begin
                        count_next   = '0;
                        cmd.checksum = crc_w;
                        if (magic_w != LOG_MAGIC || length_w > {5'd0, max_frame_bytes}) begin
                            cmd.kind   = K_EMIT;
                            cmd.status = ST_BAD_HEADER;
                            phase_next = PH_DROP;
                        end
                        else if (length_w == 32'd0) begin
                            cmd.kind = K_CHECK_EMPTY;
                        end
                        else begin
                            phase_next = PH_PAYLOAD;
                            cmd.length = length_w[LEN_W-1:0];
                            if (end_of_log) begin
                                cmd.kind   = K_EMIT;
                                cmd.status = ST_TORN_TAIL;
                            end
                        end
                    end
                    else begin
                        count_next = count_inc[LEN_W-1:0];
                        if (end_of_log) begin
                            cmd.kind   = K_EMIT;
                            cmd.status = ST_TORN_TAIL;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    cmd.length   = length_reg[LEN_W-1:0];
                    cmd.checksum = crc_word_reg;
                    if ({{(31 - LEN_W){1'b0}}, count_inc} >= length_reg) begin
                        count_next = '0;
                        phase_next = PH_HEADER;
                        cmd.kind   = K_PAY_END;
                    end
                    else begin
                        count_next = count_inc[LEN_W-1:0];
                        if (end_of_log) begin
                            cmd.kind   = K_EMIT;
                            cmd.status = ST_TORN_TAIL;
                        end
                        else begin
                            cmd.kind = K_PAY;
                        end
                    end
                end
                default:
                begin
                    cmd.kind = K_SKIP;
                end
            endcase

            // The final byte of a log returns everything to the start of a new log.
            if (end_of_log) begin
                phase_next    = PH_HEADER;
                count_next    = '0;
                magic_next    = '0;
                length_next   = '0;
                crc_word_next = '0;
                pos_next      = '0;
                start_next    = '0;
            end
        end
    end

endmodule

// ===== sv/lfc_cmd_queue.sv =====
// Short first-in first-out queue of classified words between the front and back ends.
`timescale 1ns / 1ps

module lfc_cmd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = lfc_pkg::CMDQ_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output logic [DATA_W-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/lfc_back.sv =====
// Back end: runs the payload CRC-32, checks frames and holds the result word for the consumer.
`timescale 1ns / 1ps

module lfc_back #(
    parameter int OFFSET_WIDTH = lfc_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  lfc_pkg::cmd_t           cmd,
    input  logic [OFFSET_WIDTH-1:0] cmd_offset,
    output logic                    cmd_pop,
    input  logic                    res_pop,
    output logic                    res_valid,
    output lfc_pkg::res_t           res
);
    import lfc_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic        drop_reg, drop_next;
    logic        res_valid_reg;
    res_t        res_reg;

    logic [31:0] crc_upd;
    logic        produce, slot_free, mismatch;
    logic [63:0] offset_wide;
    res_t        res_new;

    assign crc_upd     = crc_byte(crc_reg, cmd.data_byte);
    assign slot_free   = !res_valid_reg || res_pop;
    assign offset_wide = 64'(cmd_offset);

    always_comb
    begin
        produce  = 1'b0;
        mismatch = 1'b0;
        res_new                 = '0;
        res_new.status          = cmd.status;
        res_new.frame_length    = cmd.length;
        res_new.frame_offset    = offset_wide[FRAME_OFFSET_W-1:0];
        res_new.stored_checksum = cmd.checksum;
        res_new.log_done        = cmd.log_last;
        crc_next  = crc_reg;
        drop_next = drop_reg;

        case (cmd.kind)
            K_EMIT:
            begin
                produce  = 1'b1;
                crc_next = CRC_ONES;
            end
            K_CHECK_EMPTY:
            begin
                produce        = 1'b1;
                mismatch       = ((crc_reg ^ CRC_ONES) != cmd.checksum);
                res_new.status = mismatch ? ST_CHECKSUM_MISMATCH : ST_FRAME_OK;
                crc_next       = CRC_ONES;
            end
            K_PAY:
            begin
                crc_next = crc_upd;
            end
            K_PAY_END:
            begin
                produce        = 1'b1;
                mismatch       = ((crc_upd ^ CRC_ONES) != cmd.checksum);
                res_new.status = mismatch ? ST_CHECKSUM_MISMATCH : ST_FRAME_OK;
                crc_next       = CRC_ONES;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase

        // After a checksum mismatch the rest of the log is ignored.
        if (drop_reg) begin
            produce  = 1'b0;
            mismatch = 1'b0;
            crc_next = crc_reg;
        end
        if (mismatch) begin
            drop_next = 1'b1;
        end
        if (cmd.log_last) begin
            crc_next  = CRC_ONES;
            drop_next = 1'b0;
        end

        cmd_pop = cmd_valid && (!produce || slot_free);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            crc_reg       <= CRC_ONES;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else begin
            if (cmd_pop) begin
                crc_reg  <= crc_next;
                drop_reg <= drop_next;
            end
            if (cmd_pop && produce) begin
                res_valid_reg <= 1'b1;
            end
            else if (res_pop) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd_pop && produce) begin
            res_reg <= res_new;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/log_frame_checker_core.sv =====
// Top level of the log frame checker: configuration register and the front, queue and back ends.
//
//  Channel   | Handshake           | Words
//  ----------+---------------------+-------------------------------------------------------
//  input     | push / full         | data_byte, end_of_log
//  result    | empty / pop         | status, frame_length, frame_offset, stored_checksum,
//            |                     | log_done
//  config    | psel/penable/pwrite | max_frame_bytes at byte address 0
//
// One input word is taken every cycle while full is low; the byte-wide CRC-32 step in the back end sets that rate.
// A result is registered in the back end after the word that causes it has passed through the command queue.
// Reset is asynchronous and active low; there is no clearing pass after it.
// When the result register is held, the back end stops at the next command that makes a result and
// the command queue fills; full rises once it holds QUEUE_DEPTH words.
`timescale 1ns / 1ps

module log_frame_checker_core #(
    parameter int OFFSET_WIDTH = lfc_pkg::OFFSET_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = lfc_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [7:0]                           data_byte,
    input  logic                                 end_of_log,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [1:0]                           status,
    output logic [lfc_pkg::LEN_W-1:0]            frame_length,
    output logic [lfc_pkg::FRAME_OFFSET_W-1:0]   frame_offset,
    output logic [31:0]                          stored_checksum,
    output logic                                 log_done,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import lfc_pkg::*;

    localparam int Q_W = CMD_W + OFFSET_WIDTH;

    logic [LEN_W-1:0]        max_frame_reg;
    logic                    accept;
    cmd_t                    front_cmd, back_cmd;
    logic [OFFSET_WIDTH-1:0] front_offset, back_offset;
    logic [Q_W-1:0]          q_rd_data;
    logic                    q_valid, q_pop;
    logic                    res_valid;
    res_t                    res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - LEN_W){1'b0}}, max_frame_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_frame_reg <= MAX_FRAME_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            max_frame_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign accept = push && !full;

    lfc_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .end_of_log      (end_of_log),
        .max_frame_bytes (max_frame_reg),
        .cmd             (front_cmd),
        .cmd_offset      (front_offset)
    );

    lfc_cmd_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  ({front_cmd, front_offset}),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rd_data)
    );

    assign back_cmd    = cmd_t'(q_rd_data[OFFSET_WIDTH +: CMD_W]);
    assign back_offset = q_rd_data[OFFSET_WIDTH-1:0];

    lfc_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd        (back_cmd),
        .cmd_offset (back_offset),
        .cmd_pop    (q_pop),
        .res_pop    (pop),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign empty           = !res_valid;
    assign status          = res.status;
    assign frame_length    = res.frame_length;
    assign frame_offset    = res.frame_offset;
    assign stored_checksum = res.stored_checksum;
    assign log_done        = res.log_done;

endmodule

// ===== sv/lfc_checker.sv =====
// Port-level checks on the log frame checker, bound to its top level.
`timescale 1ns / 1ps

module lfc_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic [1:0]                           status,
    input  logic [lfc_pkg::LEN_W-1:0]            frame_length,
    input  logic [31:0]                          stored_checksum,
    input  logic                                 log_done,
    input  logic                                 pready
);
    import lfc_pkg::*;

    // A torn frame can only be reported by the final word of a log.
    a_torn_closes_log: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_TORN_TAIL) |-> log_done)
        else $error("torn_tail reported without log_done");

    // A rejected header never reports a trusted length.
    a_bad_header_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_BAD_HEADER) |-> (frame_length == '0))
        else $error("bad_header carries a non-zero frame_length");

    // An empty payload passes only when its stored CRC is the CRC of no bytes.
    a_empty_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_FRAME_OK && frame_length == '0) |-> (stored_checksum == 32'd0))
        else $error("empty frame passed with a non-zero checksum");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(stored_checksum)))
        else $error("waiting result changed before it was taken");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind log_frame_checker_core lfc_checker u_lfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .status          (status),
    .frame_length    (frame_length),
    .stored_checksum (stored_checksum),
    .log_done        (log_done),
    .pready          (pready)
);
